FILE: hw/rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the elevator car controller: direction
// codes, register indexes, reset values and the floor search result.
// ----------------------------------------------------------------------------
package ecc_pkg;

   localparam int unsigned FLOOR_COUNT_DEF = 10;
   localparam int unsigned FLOOR_W         = 4;
   localparam int unsigned TICK_W          = 16;
   localparam int unsigned CSR_INDEX_W     = 1;

   localparam logic [FLOOR_W-1:0] RESET_FLOOR      = 4'd1;
   localparam logic [TICK_W-1:0]  DOOR_TICKS_RST   = 16'd1500;
   localparam logic [TICK_W-1:0]  TRAVEL_TICKS_RST = 16'd1000;

   localparam logic [CSR_INDEX_W-1:0] CSR_DOOR_TICKS   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL_TICKS = 1'd1;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } ecc_dir_type;

   // nearest pending floor on either side of the car
   typedef struct packed {
      logic               above_hit;
      logic [FLOOR_W-1:0] above_floor;
      logic               below_hit;
      logic [FLOOR_W-1:0] below_floor;
   } ecc_pick_type;

endpackage

FILE: hw/rtl/ecc_pick.sv
// ----------------------------------------------------------------------------
// ecc_pick
// Priority search over the pending-stop bitmap: lowest pending floor above
// the car and highest pending floor below it.
// ----------------------------------------------------------------------------
module ecc_pick #(
   parameter int unsigned FLOOR_COUNT = ecc_pkg::FLOOR_COUNT_DEF
) (
   input  logic [FLOOR_COUNT-1:0]      pending,
   input  logic [ecc_pkg::FLOOR_W-1:0] floor_now,
   output ecc_pkg::ecc_pick_type       pick
);
   import ecc_pkg::*;

   always_comb begin
      pick = '0;
      // walk down so the lowest floor above wins
      for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
         if (pending[i] && (FLOOR_W'(i) > floor_now)) begin
            pick.above_hit   = 1'b1;
            pick.above_floor = FLOOR_W'(i);
         end
      end
      // walk up so the highest floor below wins
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (pending[i] && (FLOOR_W'(i) < floor_now)) begin
            pick.below_hit   = 1'b1;
            pick.below_floor = FLOOR_W'(i);
         end
      end
   end

endmodule

FILE: hw/rtl/elevator_car_controller_unit.sv
// ----------------------------------------------------------------------------
// elevator_car_controller_unit
// Collective-control elevator car: one request per tick updates car state.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ stream is one tick. It may carry a floor call
//   with a call direction, a button-light set and a freeze/release command.
//   For every request the block returns exactly one response on the rsp_
//   stream showing the car state after that tick (floor, door, direction,
//   target, stop/light/call bitmaps, frozen flag).
//   The csr_ channel writes the door-open and floor-travel tick counts; it is
//   always ready; the user writes it while no request is in flight (unchecked).
// Timing:
//   A request is held in the request register, then the tick update loads
//   the state registers, which double as the response register.
//   Throughput is one request per cycle while rsp_tready is high; the tick
//   update is a single pass of short logic and a FLOOR_COUNT-wide priority search.
// Reset:
//   Synchronous, active high. The car comes up on floor 1, door closed,
//   stopped, with empty bitmaps and the default tick counts.
// Backpressure:
//   While rsp_tready is low the response holds and the state freezes; one
//   more request is still taken into the request register, then req_tready
//   drops until the response is taken.
// ----------------------------------------------------------------------------
module elevator_car_controller_unit #(
   parameter int unsigned FLOOR_COUNT = ecc_pkg::FLOOR_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // request_valid[0], request_floor[4:1], request_dir[6:5], light_valid[7],
   // light_floor[11:8], freeze_valid[12], freeze_on[13], zero pad[15:14]
   input  logic [15:0]                     req_tdata,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // car_floor[3:0], door_open[4], car_direction[6:5], in_use[7],
   // target_valid[8], target_floor[12:9], travelling[13], pending_mask,
   // light_mask, up_call_mask, down_call_mask (FLOOR_COUNT bits each),
   // frozen, zero pad to whole bytes
   output logic [((15+4*FLOOR_COUNT+7)/8)*8-1:0] rsp_tdata,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ecc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ecc_pkg::TICK_W-1:0]      csr_data
);
   import ecc_pkg::*;

   localparam int unsigned RSP_BITS = 15 + 4 * FLOOR_COUNT;
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int unsigned CNT_W    = TICK_W + 1;

   // ---------------------------------------------------------------- handshake
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        req_accept;

   // ---------------------------------------------------------------- config
   logic [TICK_W-1:0] door_ticks_ff, door_ticks_in;
   logic [TICK_W-1:0] travel_ticks_ff, travel_ticks_in;

   // ---------------------------------------------------------------- car state
   logic [FLOOR_W-1:0]     floor_ff, floor_in;
   logic                   door_ff, door_in;
   ecc_dir_type            dir_ff, dir_in;
   logic                   busy_ff, busy_in;
   logic                   tgt_valid_ff, tgt_valid_in;
   logic [FLOOR_W-1:0]     tgt_ff, tgt_in;
   logic                   moving_ff, moving_in;
   logic [TICK_W-1:0]      door_cnt_ff, door_cnt_in;
   logic [TICK_W-1:0]      travel_cnt_ff, travel_cnt_in;
   logic [FLOOR_COUNT-1:0] pending_ff, pending_in;
   logic [FLOOR_COUNT-1:0] light_ff, light_in;
   logic [FLOOR_COUNT-1:0] up_ff, up_in;
   logic [FLOOR_COUNT-1:0] down_ff, down_in;
   logic                   frozen_ff, frozen_in;

   // ---------------------------------------------------------------- request fields
   logic               rq_valid, lt_valid, fz_valid, fz_on;
   logic [FLOOR_W-1:0] rq_floor, lt_floor;
   logic [1:0]         rq_dir;
   logic               rq_hit;
   logic [FLOOR_COUNT-1:0] rq_bit, pending_req;
   ecc_pick_type       pick;

   function automatic logic [FLOOR_COUNT-1:0] floor_bit(input logic [FLOOR_W-1:0] f);
      logic [FLOOR_COUNT-1:0] b;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         b[i] = (f == FLOOR_W'(i));
      end
      return b;
   endfunction

   // Advance when a tick waits and the response slot is free or being taken.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      door_ticks_in   = door_ticks_ff;
      travel_ticks_in = travel_ticks_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DOOR_TICKS:   door_ticks_in   = csr_data;
            CSR_TRAVEL_TICKS: travel_ticks_in = csr_data;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // unpack the held request
   assign rq_valid = in_data_ff[0];
   assign rq_floor = in_data_ff[4:1];
   assign rq_dir   = in_data_ff[6:5];
   assign lt_valid = in_data_ff[7];
   assign lt_floor = in_data_ff[11:8];
   assign fz_valid = in_data_ff[12];
   assign fz_on    = in_data_ff[13];

   // Out-of-range floors are ignored.
   assign rq_hit      = rq_valid && ({1'b0, rq_floor} < 5'(FLOOR_COUNT));
   assign rq_bit      = floor_bit(rq_floor);
   assign pending_req = rq_hit ? (pending_ff | rq_bit) : pending_ff;

   // Search runs on the bitmap after this tick's request; the car floor does
   // not change before arrival, and the current floor is never a candidate.
   ecc_pick #(
      .FLOOR_COUNT (FLOOR_COUNT)
   ) u_pick (
      .pending   (pending_req),
      .floor_now (floor_ff),
      .pick      (pick)
   );

   // ---------------------------------------------------------------- tick update
   always_comb begin
      logic [CNT_W-1:0]       dsum, tsum, dlim, tlim;
      logic [FLOOR_COUNT-1:0] fbit;

      floor_in      = floor_ff;
      door_in       = door_ff;
      dir_in        = dir_ff;
      busy_in       = busy_ff;
      tgt_valid_in  = tgt_valid_ff;
      tgt_in        = tgt_ff;
      moving_in     = moving_ff;
      door_cnt_in   = door_cnt_ff;
      travel_cnt_in = travel_cnt_ff;
      pending_in    = pending_req;
      light_in      = light_ff;
      up_in         = up_ff;
      down_in       = down_ff;
      frozen_in     = frozen_ff;
      fbit          = floor_bit(floor_ff);
      dsum          = '0;
      tsum          = '0;
      // A zero tick count acts as one.
      dlim = (door_ticks_ff == '0) ? CNT_W'(1) : {1'b0, door_ticks_ff};
      tlim = (travel_ticks_ff == '0) ? CNT_W'(1) : {1'b0, travel_ticks_ff};

      if (frozen_ff) begin
         // Frozen: drop everything but a release.
         pending_in = pending_ff;
         if (fz_valid && !fz_on) begin
            frozen_in = 1'b0;
         end
      end else begin
         // floor call, with retarget only to floors strictly ahead
         if (rq_hit) begin
            if (rq_dir == DIR_UP) begin
               up_in = up_in | rq_bit;
            end else if (rq_dir == DIR_DOWN) begin
               down_in = down_in | rq_bit;
            end
            if (!tgt_valid_in) begin
               tgt_in       = rq_floor;
               tgt_valid_in = 1'b1;
            end else if (rq_dir == DIR_UP && dir_in == DIR_UP &&
                         rq_floor < tgt_in && rq_floor > floor_in) begin
               tgt_in = rq_floor;
            end else if (rq_dir == DIR_DOWN && dir_in == DIR_DOWN &&
                         rq_floor > tgt_in && rq_floor < floor_in) begin
               tgt_in = rq_floor;
            end
         end

         if (lt_valid && ({1'b0, lt_floor} < 5'(FLOOR_COUNT))) begin
            light_in = light_in | floor_bit(lt_floor);
         end

         // start serving a fresh target
         if (!busy_in && tgt_valid_in) begin
            busy_in = 1'b1;
            if (tgt_in > floor_in) begin
               dir_in    = DIR_UP;
               moving_in = 1'b1;
            end else if (tgt_in < floor_in) begin
               dir_in    = DIR_DOWN;
               moving_in = 1'b1;
            end
         end

         // arrival: open, clear this floor, pick the next stop
         if (tgt_valid_in && tgt_in == floor_in && busy_in && !door_in) begin
            door_in    = 1'b1;
            pending_in = pending_in & ~fbit;
            light_in   = light_in & ~fbit;
            if (dir_in == DIR_DOWN) begin
               if (pick.below_hit) begin
                  tgt_in = pick.below_floor;
               end else if (pick.above_hit) begin
                  tgt_in = pick.above_floor;
                  dir_in = DIR_UP;
               end else begin
                  busy_in      = 1'b0;
                  dir_in       = DIR_STOP;
                  tgt_valid_in = 1'b0;
                  tgt_in       = '0;
               end
            end else begin
               // stopped searches as if going up
               if (pick.above_hit) begin
                  tgt_in = pick.above_floor;
                  dir_in = DIR_UP;
               end else if (pick.below_hit) begin
                  tgt_in = pick.below_floor;
                  dir_in = DIR_DOWN;
               end else begin
                  busy_in      = 1'b0;
                  dir_in       = DIR_STOP;
                  tgt_valid_in = 1'b0;
                  tgt_in       = '0;
               end
            end
            if (dir_in == DIR_UP) begin
               up_in = up_in & ~fbit;
            end else if (dir_in == DIR_DOWN) begin
               down_in = down_in & ~fbit;
            end else begin
               up_in   = up_in & ~fbit;
               down_in = down_in & ~fbit;
            end
         end

         // door timer
         dsum = {1'b0, door_cnt_ff} + CNT_W'(door_in);
         if (dsum >= dlim) begin
            door_in     = 1'b0;
            door_cnt_in = '0;
            if (dir_in == DIR_UP || dir_in == DIR_DOWN) begin
               moving_in = 1'b1;
            end
         end else begin
            door_cnt_in = dsum[TICK_W-1:0];
         end

         // travel timer, floor saturates at both ends
         tsum = {1'b0, travel_cnt_ff} + CNT_W'(moving_in);
         if (tsum >= tlim) begin
            travel_cnt_in = '0;
            if (dir_in == DIR_UP) begin
               if ({1'b0, floor_in} < 5'(FLOOR_COUNT - 1)) begin
                  floor_in = floor_in + FLOOR_W'(1);
               end
            end else if (dir_in == DIR_DOWN) begin
               if (floor_in != '0) begin
                  floor_in = floor_in - FLOOR_W'(1);
               end
            end
            if (tgt_valid_in && floor_in == tgt_in) begin
               moving_in = 1'b0;
            end
         end else begin
            travel_cnt_in = tsum[TICK_W-1:0];
         end

         // freeze takes effect after this tick
         if (fz_valid && fz_on) begin
            frozen_in = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         door_ticks_ff   <= DOOR_TICKS_RST;
         travel_ticks_ff <= TRAVEL_TICKS_RST;
         floor_ff        <= RESET_FLOOR;
         door_ff         <= 1'b0;
         dir_ff          <= DIR_STOP;
         busy_ff         <= 1'b0;
         tgt_valid_ff    <= 1'b0;
         tgt_ff          <= '0;
         moving_ff       <= 1'b0;
         door_cnt_ff     <= '0;
         travel_cnt_ff   <= '0;
         pending_ff      <= '0;
         light_ff        <= '0;
         up_ff           <= '0;
         down_ff         <= '0;
         frozen_ff       <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         door_ticks_ff   <= door_ticks_in;
         travel_ticks_ff <= travel_ticks_in;
         // State doubles as the response: load only when the slot frees up.
         if (advance) begin
            floor_ff      <= floor_in;
            door_ff       <= door_in;
            dir_ff        <= dir_in;
            busy_ff       <= busy_in;
            tgt_valid_ff  <= tgt_valid_in;
            tgt_ff        <= tgt_in;
            moving_ff     <= moving_in;
            door_cnt_ff   <= door_cnt_in;
            travel_cnt_ff <= travel_cnt_in;
            pending_ff    <= pending_in;
            light_ff      <= light_in;
            up_ff         <= up_in;
            down_ff       <= down_in;
            frozen_ff     <= frozen_in;
         end
      end
   end

   // request payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------- response
   // Target floor is already zero whenever no target is set.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({frozen_ff, down_ff, up_ff, light_ff, pending_ff,
                               moving_ff, tgt_ff, tgt_valid_ff, busy_ff,
                               dir_ff, door_ff, floor_ff});

endmodule
